[rtl/core/brr_pkg.sv]
// Shared types and constants for the BRR sample decoder.
// No dependencies; imported by every module of the block.
package brr_pkg;

    // Input item: one byte of a block plus its tags
    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_header;
        logic       restart;
    } brr_in_t;

    // Result item: one decoded sample
    typedef struct packed {
        logic signed [15:0] sample;
        logic               second_of_pair;
        logic               end_flag;
        logic               loop_flag;
    } brr_out_t;

    // Classified operation handed from front to back
    typedef enum logic [1:0] {
        OP_DATA   = 2'd0,
        OP_HEADER = 2'd1,
        OP_KEYON  = 2'd2
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] data_byte;
    } brr_op_t;

    // Filter select codes (header bits 3..2)
    localparam logic [1:0] FILT_NONE = 2'd0;
    localparam logic [1:0] FILT_ONE  = 2'd1;
    localparam logic [1:0] FILT_TWO  = 2'd2;
    localparam logic [1:0] FILT_THREE = 2'd3;

    // Largest shift range that scales the nibble normally
    localparam logic [3:0] RANGE_MAX = 4'd12;

    // Queue between front and back
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

endpackage : brr_pkg

[rtl/core/brr_sample_decoder_unit.sv]
// Top level of the BRR sample decoder: front, queue and back stages.
// Depends on brr_pkg, brr_front, brr_queue and brr_back.
//
// Decodes bit-rate-reduced ADPCM. Each input item is one byte of a block:
// a header byte (is_header high) loads shift range, filter, loop and end
// bits and, with restart high, clears the two-sample history; it gives no
// result. A data byte gives two signed 16-bit samples, high nibble first,
// each tagged with the current end and loop bits; second_of_pair marks the
// low-nibble sample. A data byte is decoded one nibble at a time by the
// single nibble decoder in the back stage, whose result feeds the history
// used by the very next nibble. The front register and a two-entry queue
// let input items keep arriving while a sample waits in the output
// register. The path from acceptance to the first sample runs through the
// front register, the queue and the output register. Data arriving before
// any header decodes with range 0 and no filter.
module brr_sample_decoder_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  brr_pkg::brr_in_t  src_data,
    output logic              smp_valid,
    input  logic              smp_stall,
    output brr_pkg::brr_out_t smp_data
);
    import brr_pkg::*;

    // Front to queue
    logic    op_valid;
    brr_op_t op;
    logic    q_full;

    // Queue to back
    logic    q_valid;
    brr_op_t q_op;
    logic    q_pop;

    brr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_data  (src_data),
        .op_valid  (op_valid),
        .op        (op),
        .op_full   (q_full)
    );

    brr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (op_valid),
        .push_op    (op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_op)
    );

    brr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_op      (q_op),
        .q_pop     (q_pop),
        .smp_valid (smp_valid),
        .smp_stall (smp_stall),
        .smp_data  (smp_data)
    );

endmodule : brr_sample_decoder_unit

[rtl/core/brr_front.sv]
// Front stage: accepts input items and classifies them into operations.
// Depends on brr_pkg.
module brr_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             src_valid,
    output logic             src_stall,
    input  brr_pkg::brr_in_t src_data,
    output logic             op_valid,
    output brr_pkg::brr_op_t op,
    input  logic             op_full
);
    import brr_pkg::*;

    logic    front_valid_reg;
    logic    front_valid_next;
    brr_op_t op_reg;
    brr_op_t op_next;
    logic    take;

    // Register can refill whenever it is empty or its item moves to the queue
    assign src_stall = front_valid_reg && op_full;
    assign take      = src_valid && !src_stall;

    always_comb
    begin
        op_next           = op_reg;
        op_next.data_byte = src_data.data_byte;
        if (!src_data.is_header)
        begin
            op_next.kind = OP_DATA;
        end
        else if (src_data.restart)
        begin
            op_next.kind = OP_KEYON;
        end
        else
        begin
            op_next.kind = OP_HEADER;
        end
        front_valid_next = take || (front_valid_reg && op_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg <= op_next;
        end
    end

    assign op_valid = front_valid_reg;
    assign op       = op_reg;

endmodule : brr_front

[rtl/core/brr_queue.sv]
// Short queue of classified operations between front and back.
// Depends on brr_pkg (entry type and depth).
module brr_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  brr_pkg::brr_op_t push_op,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output brr_pkg::brr_op_t head_op
);
    import brr_pkg::*;

    brr_op_t             entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    // Occupancy must rise by one on a push without a pop
    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a push");

endmodule : brr_queue

[rtl/core/brr_back.sv]
// Back stage: holds header and history, decodes nibbles one per cycle while the output is not stalled.
// Depends on brr_pkg.
module brr_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    input  brr_pkg::brr_op_t  q_op,
    output logic              q_pop,
    output logic              smp_valid,
    input  logic              smp_stall,
    output brr_pkg::brr_out_t smp_data
);
    import brr_pkg::*;

    logic [7:0]         header_reg;
    logic [7:0]         header_next;
    logic [15:0]        hist1_reg;
    logic [15:0]        hist1_next;
    logic [15:0]        hist2_reg;
    logic [15:0]        hist2_next;
    logic               phase_reg;
    logic               phase_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    brr_out_t           out_reg;
    brr_out_t           out_next;

    logic               slot_free;
    logic               fire;
    logic [3:0]         nib;
    logic [3:0]         range_sel;
    logic [1:0]         filt_sel;
    logic signed [19:0] nib_x;
    logic signed [19:0] scaled;
    logic signed [19:0] p1;
    logic signed [19:0] p2;
    logic signed [19:0] m3;
    logic signed [19:0] m13;
    logic signed [19:0] acc;
    logic [15:0]        sat;
    logic [15:0]        dec;

    assign slot_free = !out_valid_reg || !smp_stall;
    assign fire      = q_valid && (q_op.kind == OP_DATA) && slot_free;
    assign q_pop     = q_valid && ((q_op.kind != OP_DATA) || (fire && phase_reg));

    // Nibble decode and prediction
    always_comb
    begin
        range_sel = header_reg[7:4];
        filt_sel  = header_reg[3:2];
        nib       = phase_reg ? q_op.data_byte[3:0] : q_op.data_byte[7:4];
        nib_x     = 20'(signed'(nib));
        if (range_sel <= RANGE_MAX)
        begin
            scaled = (nib_x <<< range_sel) >>> 1;
        end
        else
        begin
            scaled = nib[3] ? -20'sd2048 : 20'sd0;
        end
        p1  = 20'(signed'(hist1_reg));
        p2  = 20'(signed'(hist2_reg)) >>> 1;
        m3  = -((p1 <<< 1) + p1);
        m13 = -((p1 <<< 3) + (p1 <<< 2) + p1);
        acc = scaled;
        unique case (filt_sel)
            FILT_ONE:
            begin
                acc = scaled + (p1 >>> 1) + ((-p1) >>> 5);
            end
            FILT_TWO:
            begin
                acc = scaled + p1 - p2 + (p2 >>> 4) + (m3 >>> 6);
            end
            FILT_THREE:
            begin
                acc = scaled + p1 - p2 + (m13 >>> 7) + (((p2 <<< 1) + p2) >>> 4);
            end
            default:
            begin
                acc = scaled;
            end
        endcase
        if (acc < -20'sd32768)
        begin
            sat = 16'h8000;
        end
        else if (acc > 20'sd32767)
        begin
            sat = 16'h7fff;
        end
        else
        begin
            sat = acc[15:0];
        end
        dec = {sat[14:0], 1'b0};
    end

    always_comb
    begin
        header_next    = header_reg;
        hist1_next     = hist1_reg;
        hist2_next     = hist2_reg;
        phase_next     = phase_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && smp_stall;
        if (q_valid && (q_op.kind != OP_DATA))
        begin
            header_next = q_op.data_byte;
            if (q_op.kind == OP_KEYON)
            begin
                hist1_next = '0;
                hist2_next = '0;
            end
        end
        else if (fire)
        begin
            hist2_next              = hist1_reg;
            hist1_next              = dec;
            phase_next              = !phase_reg;
            out_next.sample         = signed'(dec);
            out_next.second_of_pair = phase_reg;
            out_next.end_flag       = header_reg[0];
            out_next.loop_flag      = header_reg[1];
            out_valid_next          = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg    <= '0;
            hist1_reg     <= '0;
            hist2_reg     <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            header_reg    <= header_next;
            hist1_reg     <= hist1_next;
            hist2_reg     <= hist2_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign smp_valid = out_valid_reg;
    assign smp_data  = out_reg;

    // Half-way through a byte the same data item must still be at the head
    a_phase_on_data: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (q_valid && (q_op.kind == OP_DATA)))
        else $error("second nibble pending without a data item at the head");

    // A first-nibble sample always leaves the pair half done
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !phase_reg) |=> (phase_reg && smp_valid && !smp_data.second_of_pair))
        else $error("first sample of pair not followed by pending second");

    // Key on clears both history samples
    a_keyon_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (q_valid && (q_op.kind == OP_KEYON)) |=> ((hist1_reg == '0) && (hist2_reg == '0)))
        else $error("history not cleared by key on");

endmodule : brr_back
